// ===== sv/misvf_pkg.sv =====
// ----------------------------------------------------------------------------
// misvf_pkg
// Shared types, widths, codes and the saturation helper of the
// multi-instance state-variable filter.
// ----------------------------------------------------------------------------
package misvf_pkg;

    // defaults for the top-level parameters
    localparam int NUM_INSTANCES_DEF  = 4;
    localparam int MAX_CHANNELS_DEF   = 2;
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_FRAC_BITS_DEF = 20;

    // fixed field and datapath widths
    localparam int INST_W   = 2;
    localparam int CHAN_W   = 1;
    localparam int COEF_W   = 24;
    localparam int STATE_W  = 32;
    localparam int V3_W     = 35;                  // clamp range of the difference term
    localparam int MUL_A_W  = 35;                  // signed operand: v1 or v3
    localparam int MUL_B_W  = COEF_W + 1;          // coefficient, zero extended
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int GH_W     = 2 * COEF_W;          // g*h after the shift, split in halves
    localparam int SUM_W    = PROD_W + COEF_W + 1; // full v3*gh from two partial products
    localparam int WIDE_W   = SUM_W + 1;           // working width for add and clamp

    localparam int TYPE_W   = 8;
    localparam int ENABLE_W = 4;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // register indexes (byte address / 4)
    localparam logic REG_TYPE_SELECT = 1'b0;
    localparam logic REG_ENABLE_MASK = 1'b1;

    // response codes in type_select
    typedef logic [1:0] t_resp;
    localparam t_resp RESP_LOW   = 2'd0;
    localparam t_resp RESP_BAND  = 2'd1;
    localparam t_resp RESP_HIGH  = 2'd2;
    localparam t_resp RESP_NOTCH = 2'd3;

    // multiplier operand selection
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_GH  = 3'd0;   // g * h
    localparam t_mul_sel MUL_KV1 = 3'd1;   // k * v1
    localparam t_mul_sel MUL_LO  = 3'd2;   // v3 * gh[23:0]
    localparam t_mul_sel MUL_HI  = 3'd3;   // v3 * gh[47:24]
    localparam t_mul_sel MUL_GV1 = 3'd4;   // g * v1

    typedef struct packed {
        logic [TYPE_W-1:0]   type_select;
        logic [ENABLE_W-1:0] enable_mask;
    } t_cfg;

    typedef struct packed {
        logic     capture;
        logic     rd_state;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     gh_load;
        logic     v3_load;
        logic     acc_load;
        logic     sum_load;
        logic     v1_load;
        logic     v2_load;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
    } t_dp_status;

    typedef struct packed {
        logic signed [WIDE_W-1:0] value;
        logic                     sat;
    } t_sat_res;

    // clamp a wide signed value to an n-bit signed range
    function automatic t_sat_res sat_to(input logic signed [WIDE_W-1:0] v,
                                        input int unsigned n);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        t_sat_res                 r;
        hi = $signed((WIDE_W'(1) << (n - 1)) - WIDE_W'(1));
        lo = ~hi;
        if (v > hi) begin
            r.value = hi;
            r.sat   = 1'b1;
        end else if (v < lo) begin
            r.value = lo;
            r.sat   = 1'b1;
        end else begin
            r.value = v;
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

// ===== sv/multi_instance_svf_filter.sv =====
// ----------------------------------------------------------------------------
// multi_instance_svf_filter
// Multi-instance trapezoidal state-variable filter with APB set-up.
// ----------------------------------------------------------------------------
// Each word on the input stream carries one signed sample, the instance and
// channel it belongs to (tuser) and the g, k, h coefficients of the current
// sub-block (tdata). The pair's two integrator states update as
// v3 = x - v2 - k*v1, v1 += g*h*v3, v2 += g*v1, and the response chosen for
// the instance in type_select (lowpass, bandpass, highpass or notch) comes
// back as one output word, saturated to the sample width; tuser flags any
// saturation of v3, a state or the output. Disabled or out-of-range
// instance/channel pairs return zero and leave the states alone. An enabled
// sample runs through every step of the sequence before it reaches the
// result register, a disabled one skips from the g*h step to the last: all
// products go one after another through a single 35x25 multiplier (g*h,
// k*v1, two halves of v3*gh, g*v1, k*v1 for the output), each followed by
// its shift, add and clamp. A new sample is taken in the idle cycle after
// the previous one has reached the output register, so the input takes no
// new sample while one is still in the sequence. The output register holds
// its word until the sink takes it; while it is still held, the next sample
// waits in the last step and the input stays closed. States are zero after
// reset. Write the registers only while the block is idle.
// ----------------------------------------------------------------------------
module multi_instance_svf_filter #(
    parameter int NUM_INSTANCES  = misvf_pkg::NUM_INSTANCES_DEF,
    parameter int MAX_CHANNELS   = misvf_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH   = misvf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = misvf_pkg::COEF_FRAC_BITS_DEF,
    localparam int IN_TDATA_W    = ((SAMPLE_WIDTH + 3 * misvf_pkg::COEF_W + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, low bit up: sample_in, g_coef, k_coef, h_coef, zero pad
    input  logic [IN_TDATA_W-1:0]          s_axis_tdata,
    // tuser, low bit up: instance_index[1:0], channel_index
    input  logic [2:0]                     s_axis_tuser,
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, low bit up: sample_out, zero pad
    output logic [OUT_TDATA_W-1:0]         m_axis_tdata,
    // tuser: overflow_flag
    output logic [0:0]                     m_axis_tuser,
    // APB register port: 0x0 type_select, 0x4 enable_mask
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [misvf_pkg::APB_AW-1:0]   paddr,
    input  logic [misvf_pkg::APB_DW-1:0]   pwdata,
    output logic [misvf_pkg::APB_DW-1:0]   prdata,
    output logic                           pready
);

    localparam int CW = misvf_pkg::COEF_W;

    misvf_pkg::t_cfg        cfg;
    misvf_pkg::t_dp_cmd     cmd;
    misvf_pkg::t_dp_status  status;
    logic [SAMPLE_WIDTH-1:0] dp_sample;
    logic                    dp_flag;

    misvf_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    misvf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    // field unpacking of the input word
    misvf_dp #(
        .NUM_INSTANCES  (NUM_INSTANCES),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_cfg    (cfg),
        .i_inst   (s_axis_tuser[misvf_pkg::INST_W-1:0]),
        .i_chan   (s_axis_tuser[misvf_pkg::INST_W +: misvf_pkg::CHAN_W]),
        .i_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .i_g      (s_axis_tdata[SAMPLE_WIDTH +: CW]),
        .i_k      (s_axis_tdata[SAMPLE_WIDTH + CW +: CW]),
        .i_h      (s_axis_tdata[SAMPLE_WIDTH + 2 * CW +: CW]),
        .o_status (status),
        .o_sample (dp_sample),
        .o_flag   (dp_flag)
    );

    assign m_axis_tdata    = OUT_TDATA_W'(dp_sample);
    assign m_axis_tuser[0] = dp_flag;

endmodule

// ===== sv/misvf_apb.sv =====
// ----------------------------------------------------------------------------
// misvf_apb
// APB register file: response select and enable mask.
// ----------------------------------------------------------------------------
module misvf_apb (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [misvf_pkg::APB_AW-1:0]   paddr,
    input  logic [misvf_pkg::APB_DW-1:0]   pwdata,
    output logic [misvf_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    output misvf_pkg::t_cfg                o_cfg
);

    logic [misvf_pkg::TYPE_W-1:0]   r_type_select;
    logic [misvf_pkg::ENABLE_W-1:0] r_enable_mask;
    logic                           wr_en;
    logic                           reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_select <= '0;
            r_enable_mask <= '1;
        end else if (wr_en) begin
            unique case (reg_idx)
                misvf_pkg::REG_TYPE_SELECT:
                    r_type_select <= pwdata[misvf_pkg::TYPE_W-1:0];
                misvf_pkg::REG_ENABLE_MASK:
                    r_enable_mask <= pwdata[misvf_pkg::ENABLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            misvf_pkg::REG_TYPE_SELECT: prdata = misvf_pkg::APB_DW'(r_type_select);
            misvf_pkg::REG_ENABLE_MASK: prdata = misvf_pkg::APB_DW'(r_enable_mask);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.type_select = r_type_select;
    assign o_cfg.enable_mask = r_enable_mask;

endmodule

// ===== sv/misvf_ctrl.sv =====
// ----------------------------------------------------------------------------
// misvf_ctrl
// Sequencer: steps one sample through the shared multiplier and owns the
// output word valid.
// ----------------------------------------------------------------------------
module misvf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_out_ready,
    input  misvf_pkg::t_dp_status  i_status,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output misvf_pkg::t_dp_cmd     o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_GH   = 4'd1;
    localparam logic [3:0] ST_KV   = 4'd2;
    localparam logic [3:0] ST_V3   = 4'd3;
    localparam logic [3:0] ST_LO   = 4'd4;
    localparam logic [3:0] ST_HI   = 4'd5;
    localparam logic [3:0] ST_SUM  = 4'd6;
    localparam logic [3:0] ST_V1   = 4'd7;
    localparam logic [3:0] ST_MG   = 4'd8;
    localparam logic [3:0] ST_V2   = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = o_in_ready && i_in_valid;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = accept;
                if (accept) n_state = ST_GH;
            end
            ST_GH: begin
                o_cmd.rd_state = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = misvf_pkg::MUL_GH;
                n_state        = i_status.active ? ST_KV : ST_OUT;
            end
            ST_KV: begin
                o_cmd.gh_load = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = misvf_pkg::MUL_KV1;
                n_state       = ST_V3;
            end
            ST_V3: begin
                o_cmd.v3_load = 1'b1;
                n_state       = ST_LO;
            end
            ST_LO: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = misvf_pkg::MUL_LO;
                n_state       = ST_HI;
            end
            ST_HI: begin
                o_cmd.acc_load = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = misvf_pkg::MUL_HI;
                n_state        = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum_load = 1'b1;
                n_state        = ST_V1;
            end
            ST_V1: begin
                o_cmd.v1_load = 1'b1;
                n_state       = ST_MG;
            end
            ST_MG: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = misvf_pkg::MUL_GV1;
                n_state       = ST_V2;
            end
            ST_V2: begin
                o_cmd.v2_load = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = misvf_pkg::MUL_KV1;
                n_state       = ST_OUT;
            end
            ST_OUT: begin
                // hold here until the output register can take the word
                o_cmd.commit = out_free;
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_out_ready))
        else $error("commit while output word still held");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_GH))
        else $error("accepted word did not start the sequence");

    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("commit did not present a result");

    a_inactive_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GH && !i_status.active) |=> (r_state == ST_OUT))
        else $error("disabled word entered the filter sequence");

endmodule

// ===== sv/misvf_dp.sv =====
// ----------------------------------------------------------------------------
// misvf_dp
// Datapath: state store, one shared 35x25 multiplier, clamps and the
// output register.
// ----------------------------------------------------------------------------
module misvf_dp #(
    parameter int NUM_INSTANCES  = misvf_pkg::NUM_INSTANCES_DEF,
    parameter int MAX_CHANNELS   = misvf_pkg::MAX_CHANNELS_DEF,
    parameter int SAMPLE_WIDTH   = misvf_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = misvf_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  misvf_pkg::t_dp_cmd                 i_cmd,
    input  misvf_pkg::t_cfg                    i_cfg,
    input  logic [misvf_pkg::INST_W-1:0]       i_inst,
    input  logic [misvf_pkg::CHAN_W-1:0]       i_chan,
    input  logic [SAMPLE_WIDTH-1:0]            i_sample,
    input  logic [misvf_pkg::COEF_W-1:0]       i_g,
    input  logic [misvf_pkg::COEF_W-1:0]       i_k,
    input  logic [misvf_pkg::COEF_W-1:0]       i_h,
    output misvf_pkg::t_dp_status              o_status,
    output logic [SAMPLE_WIDTH-1:0]            o_sample,
    output logic                               o_flag
);

    localparam int SLOTS  = NUM_INSTANCES * MAX_CHANNELS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WW     = misvf_pkg::WIDE_W;
    localparam int CW     = misvf_pkg::COEF_W;

    // state store, one entry per instance/channel pair
    logic signed [misvf_pkg::STATE_W-1:0] r_band [SLOTS];
    logic signed [misvf_pkg::STATE_W-1:0] r_low  [SLOTS];

    // per-sample working registers
    logic signed [SAMPLE_WIDTH-1:0]       r_x;
    logic [CW-1:0]                        r_g;
    logic [CW-1:0]                        r_k;
    logic [CW-1:0]                        r_h;
    logic [SLOT_W-1:0]                    r_slot;
    misvf_pkg::t_resp                     r_sel;
    logic                                 r_active;
    logic                                 r_sat;
    logic signed [misvf_pkg::STATE_W-1:0] r_v1;
    logic signed [misvf_pkg::STATE_W-1:0] r_v2;
    logic signed [misvf_pkg::V3_W-1:0]    r_v3;
    logic [misvf_pkg::GH_W-1:0]           r_gh;
    logic signed [misvf_pkg::PROD_W-1:0]  r_prod;
    logic signed [misvf_pkg::PROD_W-1:0]  r_acc;
    logic signed [misvf_pkg::SUM_W-1:0]   r_sum;
    logic [SAMPLE_WIDTH-1:0]              r_y;
    logic                                 r_oflag;

    logic                                 in_active;
    logic [SLOT_W-1:0]                    in_slot;
    logic signed [misvf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [misvf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [misvf_pkg::PROD_W-1:0]  prod_sh;
    logic [misvf_pkg::PROD_W-1:0]         gh_full;
    logic signed [misvf_pkg::SUM_W-1:0]   sum_sh;
    logic signed [misvf_pkg::SUM_W-1:0]   hi_ext;
    logic signed [WW-1:0]                 x_w;
    logic signed [WW-1:0]                 v1_w;
    logic signed [WW-1:0]                 v2_w;
    logic signed [WW-1:0]                 kv_w;
    logic signed [WW-1:0]                 y_raw;
    misvf_pkg::t_sat_res                  v3_res;
    misvf_pkg::t_sat_res                  v1_res;
    misvf_pkg::t_sat_res                  v2_res;
    misvf_pkg::t_sat_res                  y_res;

    // instance and channel in range and the instance enabled
    assign in_active = (32'(i_inst) < NUM_INSTANCES) && (32'(i_chan) < MAX_CHANNELS)
                       && i_cfg.enable_mask[i_inst];
    assign in_slot   = in_active ? SLOT_W'(32'(i_inst) * MAX_CHANNELS + 32'(i_chan))
                                 : '0;
    assign o_status.active = r_active;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x      <= $signed(i_sample);
            r_g      <= i_g;
            r_k      <= i_k;
            r_h      <= i_h;
            r_slot   <= in_slot;
            r_sel    <= i_cfg.type_select[2 * i_inst +: 2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.capture) begin
            r_active <= in_active;
        end
    end

    // shared multiplier, coefficients zero extended into a signed operand
    always_comb begin
        unique case (i_cmd.mul_sel)
            misvf_pkg::MUL_GH: begin
                mul_a = $signed(misvf_pkg::MUL_A_W'(r_g));
                mul_b = $signed(misvf_pkg::MUL_B_W'(r_h));
            end
            misvf_pkg::MUL_KV1: begin
                mul_a = misvf_pkg::MUL_A_W'(r_v1);
                mul_b = $signed(misvf_pkg::MUL_B_W'(r_k));
            end
            misvf_pkg::MUL_LO: begin
                mul_a = r_v3;
                mul_b = $signed(misvf_pkg::MUL_B_W'(r_gh[CW-1:0]));
            end
            misvf_pkg::MUL_HI: begin
                mul_a = r_v3;
                mul_b = $signed(misvf_pkg::MUL_B_W'(r_gh[misvf_pkg::GH_W-1:CW]));
            end
            misvf_pkg::MUL_GV1: begin
                mul_a = misvf_pkg::MUL_A_W'(r_v1);
                mul_b = $signed(misvf_pkg::MUL_B_W'(r_g));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // floor shifts: arithmetic right shifts for the signed values, logical for g*h
    assign prod_sh = r_prod >>> COEF_FRAC_BITS;
    assign gh_full = $unsigned(r_prod) >> COEF_FRAC_BITS;
    assign sum_sh  = r_sum >>> COEF_FRAC_BITS;
    assign hi_ext  = misvf_pkg::SUM_W'(r_prod);

    assign x_w  = WW'(r_x);
    assign v1_w = WW'(r_v1);
    assign v2_w = WW'(r_v2);
    assign kv_w = WW'(prod_sh);

    always_comb begin
        unique case (r_sel)
            misvf_pkg::RESP_LOW:   y_raw = v2_w;
            misvf_pkg::RESP_BAND:  y_raw = v1_w;
            misvf_pkg::RESP_HIGH:  y_raw = x_w - kv_w - v2_w;
            misvf_pkg::RESP_NOTCH: y_raw = x_w - kv_w;
            default:               y_raw = v2_w;
        endcase
    end

    assign v3_res = misvf_pkg::sat_to(x_w - v2_w - kv_w, misvf_pkg::V3_W);
    assign v1_res = misvf_pkg::sat_to(v1_w + WW'(sum_sh), misvf_pkg::STATE_W);
    assign v2_res = misvf_pkg::sat_to(v2_w + kv_w, misvf_pkg::STATE_W);
    assign y_res  = misvf_pkg::sat_to(y_raw, SAMPLE_WIDTH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_state) begin
            r_v1 <= r_band[r_slot];
            r_v2 <= r_low[r_slot];
        end else if (i_cmd.v1_load) begin
            r_v1 <= v1_res.value[misvf_pkg::STATE_W-1:0];
        end else if (i_cmd.v2_load) begin
            r_v2 <= v2_res.value[misvf_pkg::STATE_W-1:0];
        end
        if (i_cmd.gh_load)  r_gh  <= gh_full[misvf_pkg::GH_W-1:0];
        if (i_cmd.v3_load)  r_v3  <= v3_res.value[misvf_pkg::V3_W-1:0];
        if (i_cmd.acc_load) r_acc <= r_prod;
        if (i_cmd.sum_load) r_sum <= (hi_ext <<< CW) + misvf_pkg::SUM_W'(r_acc);
    end

    // sticky saturation for the current sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sat <= 1'b0;
        end else if (i_cmd.v3_load) begin
            r_sat <= r_sat | v3_res.sat;
        end else if (i_cmd.v1_load) begin
            r_sat <= r_sat | v1_res.sat;
        end else if (i_cmd.v2_load) begin
            r_sat <= r_sat | v2_res.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < SLOTS; n++) begin
                r_band[n] <= '0;
                r_low[n]  <= '0;
            end
        end else if (i_cmd.commit && r_active) begin
            r_band[r_slot] <= r_v1;
            r_low[r_slot]  <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_active) begin
                r_y     <= y_res.value[SAMPLE_WIDTH-1:0];
                r_oflag <= r_sat | y_res.sat;
            end else begin
                r_y     <= '0;
                r_oflag <= 1'b0;
            end
        end
    end

    assign o_sample = r_y;
    assign o_flag   = r_oflag;

    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_active) |=> (r_y == '0 && !r_oflag))
        else $error("disabled word gave a non-zero result");

    a_sat_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_active && r_sat) |=> r_oflag)
        else $error("state saturation lost before output");

endmodule
